### sv/hmm_pkg.sv
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package hmm_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;

   localparam int FIELD_W = 32;
   localparam int ELEM_W  = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int FRAC_B  = FRACTION_BITS % 64;
   localparam int IDX_W   = 4;
   localparam int STEP_W  = 2;
   localparam int DEPTH   = 16;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic [IDX_W-1:0]          index_type;

   localparam field_type SAT_MAX =
      field_type'({{(FIELD_W - ELEM_W + 1){1'b0}}, {(ELEM_W - 1){1'b1}}});
   localparam field_type SAT_MIN = ~SAT_MAX;

   localparam index_type LAST_INDEX = index_type'(DEPTH - 1);

endpackage

### sv/homogeneous_matrix_multiply.sv
// ----------------------------------------------------------------------------
// homogeneous_matrix_multiply
// 4x4 signed fixed-point matrix product, left times right, one shared MAC.
// ----------------------------------------------------------------------------
// Element pairs are loaded one transfer per cycle, while req_stall is low,
// in row-major order. The sixteenth transfer starts the product: each of
// the 16 entries takes four issues through the single 32x32 multiplier
// plus a read/multiply/accumulate drain, and its result can be held back
// while the result side holds rsp_stall. req_stall stays high during that
// phase. Entries come out row-major; the last one carries rsp_last_elem.
module homogeneous_matrix_multiply (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hmm_pkg::field_type  req_left_elem,
   input  hmm_pkg::field_type  req_right_elem,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hmm_pkg::field_type  rsp_product_elem,
   output hmm_pkg::index_type  rsp_elem_index,
   output logic                rsp_clipped,
   output logic                rsp_last_elem
);
   import hmm_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]             state_ff, state_in;
   index_type              load_count_ff, load_count_in;
   index_type              entry_ff, entry_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   field_type              left_mem  [DEPTH];
   field_type              right_mem [DEPTH];

   logic signed [ELEM_W-1:0] left_rd_ff, right_rd_ff;
   logic                     rd_vld_ff, mul_vld_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                   out_vld_ff, out_vld_in;
   field_type              out_elem_ff;
   index_type              out_index_ff;
   logic                   out_clip_ff, out_last_ff;

   logic                   req_accept, issue, out_load;
   index_type              left_addr, right_addr;
   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W-ELEM_W:0]  top_bits;
   logic                   fits;
   field_type              sat_value;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign issue      = (state_ff == ST_MAC);
   assign left_addr  = {entry_ff[3:2], step_ff};
   assign right_addr = {step_ff, entry_ff[1:0]};

   assign out_load = (state_ff == ST_DRAIN) && !rd_vld_ff && !mul_vld_ff &&
                     (!out_vld_ff || !rsp_stall);

   // round toward minus infinity, then saturate
   assign shifted   = acc_ff >>> FRAC_B;
   assign top_bits  = shifted[ACC_W-1:ELEM_W-1];
   assign fits      = (&top_bits) || !(|top_bits);
   assign sat_value = fits ? field_type'(signed'(shifted[ELEM_W-1:0])) :
                      (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      entry_in      = entry_ff;
      step_in       = step_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               load_count_in = load_count_ff + 4'd1;
               if (load_count_ff == LAST_INDEX) begin
                  state_in = ST_MAC;
                  entry_in = '0;
                  step_in  = '0;
               end
            end
         end
         ST_MAC: begin
            step_in = step_ff + 2'd1;
            if (step_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               entry_in = entry_ff + 4'd1;
               step_in  = '0;
               state_in = (entry_ff == LAST_INDEX) ? ST_LOAD : ST_MAC;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (out_load) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_mem[load_count_ff]  <= req_left_elem;
         right_mem[load_count_ff] <= req_right_elem;
      end
      if (issue) begin
         left_rd_ff  <= left_mem[left_addr][ELEM_W-1:0];
         right_rd_ff <= right_mem[right_addr][ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         entry_ff      <= '0;
         step_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         mul_vld_ff    <= 1'b0;
         out_vld_ff    <= 1'b0;
         acc_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         entry_ff      <= entry_in;
         step_ff       <= step_in;
         rd_vld_ff     <= issue;
         mul_vld_ff    <= rd_vld_ff;
         out_vld_ff    <= out_vld_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= left_rd_ff * right_rd_ff;
      if (out_load) begin
         out_elem_ff  <= sat_value;
         out_index_ff <= entry_ff;
         out_clip_ff  <= !fits;
         out_last_ff  <= (entry_ff == LAST_INDEX);
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_product_elem = out_elem_ff;
   assign rsp_elem_index   = out_index_ff;
   assign rsp_clipped      = out_clip_ff;
   assign rsp_last_elem    = out_last_ff;

endmodule

### sv/hmm_checker.sv
// ----------------------------------------------------------------------------
// hmm_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module hmm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input hmm_pkg::field_type  req_left_elem,
   input hmm_pkg::field_type  req_right_elem,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input hmm_pkg::field_type  rsp_product_elem,
   input hmm_pkg::index_type  rsp_elem_index,
   input logic                rsp_clipped,
   input logic                rsp_last_elem
);
   import hmm_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_left_elem) &&
      $stable(req_right_elem))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_elem) &&
      $stable(rsp_elem_index))
      else $error("result changed while stalled");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_elem == (rsp_elem_index == LAST_INDEX)))
      else $error("last marker does not match final entry");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
      (rsp_product_elem == SAT_MAX) || (rsp_product_elem == SAT_MIN))
      else $error("clipped entry is not a saturation bound");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_elem) ##1 rsp_valid |->
      rsp_elem_index == $past(rsp_elem_index) + 4'd1)
      else $error("entries out of row-major order");

endmodule

bind homogeneous_matrix_multiply hmm_checker u_hmm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_left_elem    (req_left_elem),
   .req_right_elem   (req_right_elem),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_product_elem (rsp_product_elem),
   .rsp_elem_index   (rsp_elem_index),
   .rsp_clipped      (rsp_clipped),
   .rsp_last_elem    (rsp_last_elem)
);
